### rtl/core/wles_pkg.sv
package wles_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int LIGHTS_DEF = 32;

    // input operation codes
    typedef enum logic [2:0] {
        FUNC_ON        = 3'd0,
        FUNC_OFF       = 3'd1,
        FUNC_REMOVE    = 3'd2,
        FUNC_RANDOMIZE = 3'd3,
        FUNC_TICK      = 3'd4
    } func_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ID_OOB    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // day codes
    localparam logic [3:0] DAY_SUN = 4'd0;
    localparam logic [3:0] DAY_MON = 4'd1;
    localparam logic [3:0] DAY_FRI = 4'd5;
    localparam logic [3:0] DAY_SAT = 4'd6;
    localparam logic [3:0] DAY_ALL = 4'd7;
    localparam logic [3:0] DAY_WKD = 4'd8;
    localparam logic [3:0] DAY_WKE = 4'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_addr;
    } dp_status_t;

    // one table entry
    typedef struct packed {
        logic [7:0]         light;
        logic [3:0]         day;
        logic [10:0]        minute;
        logic               is_on;
        logic               randomized;
        logic signed [5:0]  offset;
    } slot_rec_t;

    function automatic logic day_responds(logic [3:0] today, logic [3:0] sched);
        logic r;
        r = (sched == DAY_ALL) || (sched == today)
            || ((sched == DAY_WKE) && ((today == DAY_SAT) || (today == DAY_SUN)))
            || ((sched == DAY_WKD) && (today inside {[DAY_MON:DAY_FRI]}));
        return r;
    endfunction

endpackage

### rtl/core/weekly_light_event_scheduler_core.sv
// weekly light event scheduler
// command channel: a transaction is taken on a rising edge with start high and
//   busy low; func, light_id, day_code, minute and random_offset are sampled then
// result channel: each result sits on status, fire, out_light, turn_on and last
//   for one cycle with result_valid high; the receiver cannot stall it
// every transaction scans the whole slot table, one slot a cycle through the
//   registered read port of the slot memory, and holds busy high until its
//   final result; the next may be taken as soon as busy drops
// schedule, remove, randomize and unused codes give one result, with last set,
//   in the same cycle as busy drops
// a tick gives one result per firing slot in slot order; each fired result is
//   held until the next hit or the end of the scan shows whether it is the final
//   one, so fired results come out during the scan and the final one after it
// a tick with no hit gives one result with fire low
// reset (rst_n low, asynchronous) clears every valid bit, so the table is empty;
//   the slot fields themselves are not cleared
module weekly_light_event_scheduler_core
#(
    parameter int SLOTS  = wles_pkg::SLOTS_DEF,
    parameter int LIGHTS = wles_pkg::LIGHTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [7:0]         light_id,
    input  logic [3:0]         day_code,
    input  logic [10:0]        minute,
    input  logic signed [5:0]  random_offset,
    output logic               result_valid,
    output logic [1:0]         status,
    output logic               fire,
    output logic [7:0]         out_light,
    output logic               turn_on,
    output logic               last
);

    // command and status between sequencer and table datapath
    wles_pkg::ctrl_cmd_t  cmd;
    wles_pkg::dp_status_t dp_status;

    // sequencer: idle, scan, drain the read pipe, deliver the final result
    wles_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // slot memory, valid bits, match logic and result registers
    wles_datapath
    #(
        .SLOTS  (SLOTS),
        .LIGHTS (LIGHTS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .func          (func),
        .light_id      (light_id),
        .day_code      (day_code),
        .minute        (minute),
        .random_offset (random_offset),
        .result_valid  (result_valid),
        .status        (status),
        .fire          (fire),
        .out_light     (out_light),
        .turn_on       (turn_on),
        .last          (last)
    );

endmodule

### rtl/core/wles_ctrl.sv
module wles_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  wles_pkg::dp_status_t    dp_status,
    output wles_pkg::ctrl_cmd_t     cmd,
    output logic                    busy
);

    wles_pkg::state_t state_reg;
    wles_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wles_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wles_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = wles_pkg::S_SCAN;
                end
            end
            wles_pkg::S_SCAN:
            begin
                if (dp_status.last_addr)
                begin
                    state_next = wles_pkg::S_DRAIN;
                end
            end
            wles_pkg::S_DRAIN:
            begin
                state_next = wles_pkg::S_DONE;
            end
            wles_pkg::S_DONE:
            begin
                state_next = wles_pkg::S_IDLE;
            end
            default:
            begin
                state_next = wles_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            wles_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            wles_pkg::S_SCAN:
            begin
                cmd.read = 1'b1;
            end
            wles_pkg::S_DRAIN:
            begin
                cmd = '0;
            end
            wles_pkg::S_DONE:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/wles_datapath.sv
module wles_datapath
#(
    parameter int SLOTS  = wles_pkg::SLOTS_DEF,
    parameter int LIGHTS = wles_pkg::LIGHTS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wles_pkg::ctrl_cmd_t     cmd,
    output wles_pkg::dp_status_t    dp_status,
    input  logic [2:0]              func,
    input  logic [7:0]              light_id,
    input  logic [3:0]              day_code,
    input  logic [10:0]             minute,
    input  logic signed [5:0]       random_offset,
    output logic                    result_valid,
    output logic [1:0]              status,
    output logic                    fire,
    output logic [7:0]              out_light,
    output logic                    turn_on,
    output logic                    last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // slot table
    wles_pkg::slot_rec_t mem [SLOTS];
    logic [SLOTS-1:0]    valid_reg;
    wles_pkg::slot_rec_t rd_data_reg;

    // captured item
    wles_pkg::func_t     func_reg;
    logic [7:0]          light_reg;
    logic [3:0]          day_reg;
    logic [10:0]         minute_reg;
    logic signed [5:0]   roff_reg;
    logic                bad_reg;

    // scan pointers
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                chk_vld_reg;
    logic                found_reg;

    // held fired slot, emitted once the next one or the end is known
    logic                pend_vld_reg;
    logic [7:0]          pend_light_reg;
    logic                pend_on_reg;

    // result registers
    logic                res_vld_reg;
    logic [1:0]          res_status_reg;
    logic                res_fire_reg;
    logic [7:0]          res_light_reg;
    logic                res_on_reg;
    logic                res_last_reg;

    wles_pkg::slot_rec_t rec;
    wles_pkg::slot_rec_t wr_rec;
    logic                wr_en;
    logic                valid_set;
    logic                valid_clr;
    logic                found_set;
    logic                id_match;
    logic                time_match;
    logic                hit;
    logic signed [12:0]  min_sum;
    logic                emit;
    logic [1:0]          emit_status;
    logic                emit_fire;
    logic [7:0]          emit_light;
    logic                emit_on;
    logic                emit_last;
    logic [1:0]          final_status;

    assign dp_status.last_addr = (rd_idx_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        rec        = rd_data_reg;
        id_match   = valid_reg[chk_idx_reg] && (rec.light == light_reg)
                     && (rec.day == day_reg) && (rec.minute == minute_reg);
        min_sum    = $signed({2'b00, rec.minute}) + 13'(rec.offset);
        time_match = (min_sum == $signed({2'b00, minute_reg}));
        hit        = valid_reg[chk_idx_reg] && time_match
                     && wles_pkg::day_responds(day_reg, rec.day);
    end

    always_comb
    begin
        case (func_reg)
            wles_pkg::FUNC_ON, wles_pkg::FUNC_OFF:
            begin
                final_status = bad_reg ? wles_pkg::ST_ID_OOB
                             : (found_reg ? wles_pkg::ST_OK : wles_pkg::ST_FULL);
            end
            wles_pkg::FUNC_REMOVE:
            begin
                final_status = bad_reg ? wles_pkg::ST_ID_OOB
                             : (found_reg ? wles_pkg::ST_OK : wles_pkg::ST_NOT_FOUND);
            end
            default:
            begin
                final_status = wles_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        wr_en       = 1'b0;
        wr_rec      = rec;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        found_set   = 1'b0;
        emit        = 1'b0;
        emit_status = wles_pkg::ST_OK;
        emit_fire   = 1'b0;
        emit_light  = 8'd0;
        emit_on     = 1'b0;
        emit_last   = 1'b0;
        if (chk_vld_reg && !bad_reg)
        begin
            case (func_reg)
                wles_pkg::FUNC_ON, wles_pkg::FUNC_OFF:
                begin
                    if (!found_reg && !valid_reg[chk_idx_reg])
                    begin
                        wr_en             = 1'b1;
                        wr_rec.light      = light_reg;
                        wr_rec.day        = day_reg;
                        wr_rec.minute     = minute_reg;
                        wr_rec.is_on      = (func_reg == wles_pkg::FUNC_ON);
                        wr_rec.randomized = 1'b0;
                        wr_rec.offset     = '0;
                        valid_set         = 1'b1;
                        found_set         = 1'b1;
                    end
                end
                wles_pkg::FUNC_REMOVE:
                begin
                    if (!found_reg && id_match)
                    begin
                        valid_clr = 1'b1;
                        found_set = 1'b1;
                    end
                end
                wles_pkg::FUNC_RANDOMIZE:
                begin
                    if (id_match)
                    begin
                        wr_en             = 1'b1;
                        wr_rec.randomized = 1'b1;
                        wr_rec.offset     = roff_reg;
                    end
                end
                wles_pkg::FUNC_TICK:
                begin
                    if (hit)
                    begin
                        wr_en         = 1'b1;
                        wr_rec.offset = rec.randomized ? roff_reg : 6'sd0;
                        // a later hit proves the held one is not the final
                        if (pend_vld_reg)
                        begin
                            emit       = 1'b1;
                            emit_fire  = 1'b1;
                            emit_light = pend_light_reg;
                            emit_on    = pend_on_reg;
                        end
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (cmd.finish)
        begin
            emit      = 1'b1;
            emit_last = 1'b1;
            if (func_reg == wles_pkg::FUNC_TICK)
            begin
                emit_fire  = pend_vld_reg;
                emit_light = pend_vld_reg ? pend_light_reg : 8'd0;
                emit_on    = pend_vld_reg && pend_on_reg;
            end
            else
            begin
                emit_status = final_status;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_idx_reg];
            chk_idx_reg <= rd_idx_reg;
        end
        if (wr_en)
        begin
            mem[chk_idx_reg] <= wr_rec;
        end
        if (cmd.load)
        begin
            func_reg   <= wles_pkg::func_t'(func);
            light_reg  <= light_id;
            day_reg    <= day_code;
            minute_reg <= minute;
            roff_reg   <= random_offset;
            bad_reg    <= (func <= 3'(wles_pkg::FUNC_REMOVE))
                          && ({1'b0, light_id} >= 9'(LIGHTS));
        end
        if (chk_vld_reg && hit && (func_reg == wles_pkg::FUNC_TICK) && !bad_reg)
        begin
            pend_light_reg <= rec.light;
            pend_on_reg    <= rec.is_on;
        end
        if (emit)
        begin
            res_status_reg <= emit_status;
            res_fire_reg   <= emit_fire;
            res_light_reg  <= emit_light;
            res_on_reg     <= emit_on;
            res_last_reg   <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_idx_reg   <= '0;
            chk_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= cmd.read;
            res_vld_reg <= emit;
            if (cmd.load)
            begin
                rd_idx_reg   <= '0;
                found_reg    <= 1'b0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (cmd.read)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (found_set)
                begin
                    found_reg <= 1'b1;
                end
                if (chk_vld_reg && hit && (func_reg == wles_pkg::FUNC_TICK) && !bad_reg)
                begin
                    pend_vld_reg <= 1'b1;
                end
            end
            if (valid_set)
            begin
                valid_reg[chk_idx_reg] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
        end
    end

    assign result_valid = res_vld_reg;
    assign status       = res_status_reg;
    assign fire         = res_fire_reg;
    assign out_light    = res_light_reg;
    assign turn_on      = res_on_reg;
    assign last         = res_last_reg;

endmodule

### rtl/core/wles_checker.sv
module wles_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  status,
    input logic        fire,
    input logic        last
);

    // an accepted transaction occupies the block
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // the end of a transaction is always marked by its final result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last)
        else $error("busy dropped without a final result");

    // non-final results only come out while the scan runs
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy && fire)
        else $error("non-final result outside a scan");

    // a fired light always has ok status
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fire |-> status == wles_pkg::ST_OK)
        else $error("fired result with error status");

endmodule

bind weekly_light_event_scheduler_core wles_checker u_wles_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .fire         (fire),
    .last         (last)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int N_SLOTS   = wles_pkg::SLOTS_DEF;
    localparam int N_LIGHTS  = wles_pkg::LIGHTS_DEF;
    localparam int IDLE_PCT  = 15;
    localparam int POOL_SIZE = 6;
    localparam int MAX_PRINT = 200;

    // codes the block does not use, and day codes beyond weekend
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam logic [3:0] DAY_WED          = 4'd3;
    localparam logic [3:0] DAY_ODD_FIRST    = 4'd10;
    localparam logic [3:0] DAY_ODD_LAST     = 4'd15;

    // one result as the block presents it
    typedef struct packed {
        logic [1:0] status;
        logic       fire;
        logic [7:0] light;
        logic       turn_on;
        logic       last;
    } light_cmd_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        func;
    logic [7:0]        light_id;
    logic [3:0]        day_code;
    logic [10:0]       minute;
    logic signed [5:0] random_offset;
    logic              result_valid;
    logic [1:0]        status;
    logic              fire;
    logic [7:0]        out_light;
    logic              turn_on;
    logic              last;

    // expected light commands, oldest first
    light_cmd_t expected_cmds[$];

    // our own copy of the event table
    logic              tbl_valid  [N_SLOTS];
    logic [7:0]        tbl_light  [N_SLOTS];
    logic [3:0]        tbl_day    [N_SLOTS];
    logic [10:0]       tbl_minute [N_SLOTS];
    logic              tbl_on     [N_SLOTS];
    logic              tbl_rand   [N_SLOTS];
    logic signed [5:0] tbl_offset [N_SLOTS];

    int errors;
    int items_sent;
    int results_seen;
    int fires_seen;
    int idle_pct;

    weekly_light_event_scheduler_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .light_id      (light_id),
        .day_code      (day_code),
        .minute        (minute),
        .random_offset (random_offset),
        .result_valid  (result_valid),
        .status        (status),
        .fire          (fire),
        .out_light     (out_light),
        .turn_on       (turn_on),
        .last          (last)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINT)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    // does a slot with day code sched respond on day today
    function automatic logic day_hits(input logic [3:0] today, input logic [3:0] sched);
        logic hit;
        hit = (sched == wles_pkg::DAY_ALL) || (sched == today);
        if ((sched == wles_pkg::DAY_WKE)
            && ((today == wles_pkg::DAY_SAT) || (today == wles_pkg::DAY_SUN)))
        begin
            hit = 1'b1;
        end
        if ((sched == wles_pkg::DAY_WKD) && (today >= wles_pkg::DAY_MON)
            && (today <= wles_pkg::DAY_FRI))
        begin
            hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic int count_valid();
        int n;
        n = 0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (tbl_valid[i])
            begin
                n++;
            end
        end
        return n;
    endfunction

    // index of a random valid slot, or -1 when the table is empty
    function automatic int pick_slot();
        int k;
        if (count_valid() == 0)
        begin
            return -1;
        end
        k = $urandom_range(count_valid() - 1);
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (tbl_valid[i])
            begin
                if (k == 0)
                begin
                    return i;
                end
                k--;
            end
        end
        return -1;
    endfunction

    // update the table for one accepted transaction and queue its results
    task automatic predict_item(input logic [2:0] f, input logic [7:0] lid,
                                input logic [3:0] dc, input logic [10:0] mn,
                                input logic signed [5:0] ro);
        light_cmd_t res;
        light_cmd_t pend;
        logic       have_pend;
        logic [1:0] st;
        logic       done;
        res       = '0;
        pend      = '0;
        have_pend = 1'b0;
        st        = wles_pkg::ST_OK;
        done      = 1'b0;
        if ((f == wles_pkg::FUNC_ON) || (f == wles_pkg::FUNC_OFF))
        begin
            if (lid >= N_LIGHTS)
            begin
                st = wles_pkg::ST_ID_OOB;
            end
            else
            begin
                st = wles_pkg::ST_FULL;
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (!tbl_valid[i] && !done)
                    begin
                        tbl_valid[i]  = 1'b1;
                        tbl_light[i]  = lid;
                        tbl_day[i]    = dc;
                        tbl_minute[i] = mn;
                        tbl_on[i]     = (f == wles_pkg::FUNC_ON);
                        tbl_rand[i]   = 1'b0;
                        tbl_offset[i] = '0;
                        st            = wles_pkg::ST_OK;
                        done          = 1'b1;
                    end
                end
            end
        end
        else if (f == wles_pkg::FUNC_REMOVE)
        begin
            if (lid >= N_LIGHTS)
            begin
                st = wles_pkg::ST_ID_OOB;
            end
            else
            begin
                st = wles_pkg::ST_NOT_FOUND;
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (tbl_valid[i] && !done && tbl_light[i] == lid
                        && tbl_day[i] == dc && tbl_minute[i] == mn)
                    begin
                        tbl_valid[i] = 1'b0;
                        st           = wles_pkg::ST_OK;
                        done         = 1'b1;
                    end
                end
            end
        end
        else if (f == wles_pkg::FUNC_RANDOMIZE)
        begin
            for (int i = 0; i < N_SLOTS; i++)
            begin
                if (tbl_valid[i] && tbl_light[i] == lid && tbl_day[i] == dc
                    && tbl_minute[i] == mn)
                begin
                    tbl_rand[i]   = 1'b1;
                    tbl_offset[i] = ro;
                end
            end
        end
        else if (f == wles_pkg::FUNC_TICK)
        begin
            // a fired command is held back until we know whether it is the final one
            for (int i = 0; i < N_SLOTS; i++)
            begin
                if (tbl_valid[i] && day_hits(dc, tbl_day[i])
                    && (int'(tbl_minute[i]) + int'(tbl_offset[i]) == int'(mn)))
                begin
                    if (have_pend)
                    begin
                        expected_cmds.push_back(pend);
                    end
                    pend         = '0;
                    pend.fire    = 1'b1;
                    pend.light   = tbl_light[i];
                    pend.turn_on = tbl_on[i];
                    have_pend    = 1'b1;
                    tbl_offset[i] = tbl_rand[i] ? ro : 6'sd0;
                end
            end
            if (have_pend)
            begin
                pend.last = 1'b1;
                expected_cmds.push_back(pend);
                return;
            end
        end
        res.status = st;
        res.last   = 1'b1;
        expected_cmds.push_back(res);
    endtask

    // offer one transaction; start drops at random cycles while we wait for busy low
    task automatic send_item(input logic [2:0] f, input logic [7:0] lid,
                             input logic [3:0] dc, input logic [10:0] mn,
                             input logic signed [5:0] ro);
        logic taken;
        taken = 1'b0;
        func          <= f;
        light_id      <= lid;
        day_code      <= dc;
        minute        <= mn;
        random_offset <= ro;
        while (!taken)
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            taken = start && !busy;
        end
        items_sent++;
        predict_item(f, lid, dc, mn, ro);
    endtask

    // called straight after send_item: stop offering and let every result arrive
    task automatic wait_idle();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while ((expected_cmds.size() != 0) || busy);
    endtask

    task automatic test_schedule_and_bounds();
        send_item(wles_pkg::FUNC_ON,  8'd0, wles_pkg::DAY_SUN, 11'd0, 6'sd0);
        send_item(wles_pkg::FUNC_OFF, 8'(N_LIGHTS - 1), wles_pkg::DAY_SAT, 11'd1439, 6'sd0);
        send_item(wles_pkg::FUNC_ON,  8'd5, wles_pkg::DAY_WKD, 11'd600, 6'sd0);
        send_item(wles_pkg::FUNC_OFF, 8'd9, wles_pkg::DAY_WKE, 11'd720, -6'sd32);
        // light numbers just past and far past the last light
        send_item(wles_pkg::FUNC_ON,     8'(N_LIGHTS), wles_pkg::DAY_SUN, 11'd0, 6'sd0);
        send_item(wles_pkg::FUNC_OFF,    8'd255, wles_pkg::DAY_ALL, 11'd2047, 6'sd31);
        send_item(wles_pkg::FUNC_REMOVE, 8'd200, wles_pkg::DAY_SUN, 11'd0, 6'sd0);
        // remove with no matching entry
        send_item(wles_pkg::FUNC_REMOVE, 8'd5, wles_pkg::DAY_WKD, 11'd601, 6'sd0);
        wait_idle();
    endtask

    task automatic test_tick_days();
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SUN, 11'd0,    6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SAT, 11'd1439, 6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0, DAY_WED,           11'd600,  6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SUN, 11'd600,  6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SUN, 11'd720,  6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SAT, 11'd720,  6'sd0);
        // tick carrying a grouped day code: only equal codes and everyday respond
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_WKE, 11'd720,  6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_ALL, 11'd600,  6'sd0);
        wait_idle();
    endtask

    task automatic test_offsets_and_codes();
        send_item(wles_pkg::FUNC_RANDOMIZE, 8'(N_LIGHTS - 1), wles_pkg::DAY_SAT, 11'd1439,
                  6'sd5);
        // randomize matching nothing still reports ok
        send_item(wles_pkg::FUNC_RANDOMIZE, 8'd3, wles_pkg::DAY_SUN, 11'd0, 6'sd7);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SAT, 11'd1439, 6'sd0);
        // past midnight: no wrap, so the sum itself must match
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SAT, 11'd1444, 6'sd31);
        send_item(wles_pkg::FUNC_TICK, 8'd0, wles_pkg::DAY_SAT, 11'd1470, -6'sd32);
        // a day code above weekend matches only itself
        send_item(wles_pkg::FUNC_ON,   8'd17, 4'd12, 11'd100, 6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0,  4'd12, 11'd100, 6'sd0);
        send_item(wles_pkg::FUNC_TICK, 8'd0,  wles_pkg::DAY_ALL, 11'd100, 6'sd0);
        send_item(FUNC_SPARE_FIRST, 8'd255, DAY_ODD_LAST,      11'd2047, -6'sd1);
        send_item(FUNC_SPARE_LAST,  8'd0,   wles_pkg::DAY_SUN, 11'd0,    6'sd0);
        send_item(wles_pkg::FUNC_REMOVE, 8'd5,  wles_pkg::DAY_WKD, 11'd600, 6'sd0);
        send_item(wles_pkg::FUNC_REMOVE, 8'd17, 4'd12,             11'd100, 6'sd0);
        send_item(wles_pkg::FUNC_TICK,   8'd0,  DAY_ODD_LAST,      11'd2047, 6'sd0);
        wait_idle();
    endtask

    // fill every slot with no idling, overflow it, fire all at once, then thin it out
    task automatic test_full_table();
        logic [10:0] fill_min;
        fill_min = 11'($urandom_range(2047));
        idle_pct = 0;
        while (count_valid() < N_SLOTS)
        begin
            send_item($urandom_range(1) ? wles_pkg::FUNC_ON : wles_pkg::FUNC_OFF,
                      8'($urandom_range(N_LIGHTS - 1)), wles_pkg::DAY_ALL, fill_min,
                      6'($urandom));
        end
        send_item(wles_pkg::FUNC_ON, 8'($urandom_range(N_LIGHTS - 1)), wles_pkg::DAY_ALL,
                  fill_min, 6'($urandom));
        send_item(wles_pkg::FUNC_TICK, 8'($urandom), 4'($urandom_range(wles_pkg::DAY_SAT)),
                  fill_min, 6'($urandom));
        idle_pct = IDLE_PCT;
        for (int k = 0; k < N_SLOTS / 2; k++)
        begin
            int s;
            s = pick_slot();
            send_item(wles_pkg::FUNC_REMOVE, tbl_light[s], tbl_day[s], tbl_minute[s],
                      6'($urandom));
        end
        wait_idle();
    endtask

    // mostly sequences that reach real entries, with some noise around them
    task automatic test_random_mix(input int n_items);
        logic [10:0]       pool [POOL_SIZE];
        logic [2:0]        f;
        logic [7:0]        lid;
        logic [3:0]        dc;
        logic [10:0]       mn;
        logic signed [5:0] ro;
        int                pick;
        int                s;
        int                target;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool[i] = 11'($urandom_range(2047));
        end
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(99);
            s    = pick_slot();
            if ($urandom_range(9) == 0)
                lid = 8'($urandom);
            else
                lid = 8'($urandom_range(N_LIGHTS - 1));
            if ($urandom_range(6) == 0)
                dc = 4'($urandom_range(DAY_ODD_LAST, DAY_ODD_FIRST));
            else
                dc = 4'($urandom_range(wles_pkg::DAY_WKE));
            if ($urandom_range(4) == 0)
                mn = 11'($urandom);
            else
                mn = pool[$urandom_range(POOL_SIZE - 1)];
            ro = 6'($urandom);
            if (pick < 30)
            begin
                f = $urandom_range(1) ? wles_pkg::FUNC_ON : wles_pkg::FUNC_OFF;
            end
            else if (pick < 55)
            begin
                f = (pick < 45) ? wles_pkg::FUNC_REMOVE : wles_pkg::FUNC_RANDOMIZE;
                if ((s >= 0) && ($urandom_range(3) != 0))
                begin
                    lid = tbl_light[s];
                    dc  = tbl_day[s];
                    mn  = tbl_minute[s];
                end
            end
            else if (pick < 95)
            begin
                f = wles_pkg::FUNC_TICK;
                if ($urandom_range(9) == 0)
                    dc = 4'($urandom);
                else
                    dc = 4'($urandom_range(wles_pkg::DAY_SAT));
                // aim most ticks at an entry that is due
                if ((s >= 0) && ($urandom_range(4) != 0))
                begin
                    target = int'(tbl_minute[s]) + int'(tbl_offset[s]);
                    if ((target >= 0) && (target <= 2047))
                    begin
                        mn = 11'(target);
                    end
                    if (tbl_day[s] <= wles_pkg::DAY_SAT)
                    begin
                        dc = tbl_day[s];
                    end
                end
            end
            else
            begin
                f = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
            end
            send_item(f, lid, dc, mn, ro);
        end
        wait_idle();
    endtask

    // every result strobe is compared with the oldest expectation
    always @(posedge clk)
    begin : check_results
        light_cmd_t got;
        light_cmd_t want;
        if (rst_n && result_valid)
        begin
            got = {status, fire, out_light, turn_on, last};
            results_seen++;
            if (got.fire === 1'b1)
            begin
                fires_seen++;
            end
            if (expected_cmds.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result st=%0d fire=%0d light=%0d",
                                          got.status, got.fire, got.light));
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (got !== want)
                begin
                    report_mismatch($sformatf(
                        "got st=%0d fire=%0d light=%0d on=%0d last=%0d, exp %0d %0d %0d %0d %0d",
                        got.status, got.fire, got.light, got.turn_on, got.last,
                        want.status, want.fire, want.light, want.turn_on, want.last));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = wles_pkg::FUNC_ON;
        light_id      = '0;
        day_code      = wles_pkg::DAY_SUN;
        minute        = '0;
        random_offset = '0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        fires_seen    = 0;
        idle_pct      = IDLE_PCT;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_schedule_and_bounds();
        test_tick_days();
        test_offsets_and_codes();
        test_full_table();
        test_random_mix(40);

        // quiet tail to catch stray strobes
        repeat (N_SLOTS + 8) @(posedge clk);
        if (expected_cmds.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_cmds.size()));
        end
        $display("ran %0d transactions over schedule, remove, randomize, tick and spare codes",
                 items_sent);
        $display("checked %0d results, %0d of them light commands, %0d mismatches",
                 results_seen, fires_seen, errors);
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/wles_pkg.sv
rtl/core/wles_ctrl.sv
rtl/core/wles_datapath.sv
rtl/core/weekly_light_event_scheduler_core.sv
rtl/core/wles_checker.sv
bench/tb_top.sv
